/* src/pid_controller_step_unit_defines.svh */
// assertion macros shared by the pid controller step unit rtl
`ifndef PID_CONTROLLER_STEP_UNIT_DEFINES_SVH
`define PID_CONTROLLER_STEP_UNIT_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, checked on every rising edge outside reset
`define PCS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcs assertion failed");
// next-cycle implication
`define PCS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcs assertion failed");
`else
`define PCS_ASSERT_IMP(label, ante, cons)
`define PCS_ASSERT_NXT(label, ante, cons)
`endif

`endif

/* src/pcs_pkg.sv */
// shared types and constants of the pid controller step unit
`timescale 1ns / 1ps

package pcs_pkg;

  localparam int GAIN_WIDTH  = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int OUT_HIGH_RST = 255;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HIGH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE    = 3'd5;

  // mode bits steering the datapath
  typedef struct packed {
    logic auto_en;
    logic was_auto;
    logic reverse;
  } ctl_t;

endpackage

/* src/pcs_datapath.sv */
// single-pass pid arithmetic: integrator update, output sum, round and clamp
`timescale 1ns / 1ps

module pcs_datapath #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 12
) (
  input  pcs_pkg::ctl_t                          ctl,
  input  logic signed [pcs_pkg::GAIN_WIDTH-1:0]  prop_gain,
  input  logic signed [pcs_pkg::GAIN_WIDTH-1:0]  integ_gain,
  input  logic signed [pcs_pkg::GAIN_WIDTH-1:0]  deriv_gain,
  input  logic signed [DATA_WIDTH-1:0]           out_low,
  input  logic signed [DATA_WIDTH-1:0]           out_high,
  input  logic signed [DATA_WIDTH-1:0]           measured,
  input  logic signed [DATA_WIDTH-1:0]           target,
  input  logic signed [DATA_WIDTH-1:0]           manual_drive,
  input  logic signed [DATA_WIDTH+FRAC_BITS-1:0] integ_q,
  input  logic signed [DATA_WIDTH-1:0]           prev_meas_q,
  input  logic signed [DATA_WIDTH-1:0]           prev_drive_q,
  output logic signed [DATA_WIDTH+FRAC_BITS-1:0] integ_nxt,
  output logic signed [DATA_WIDTH-1:0]           drive,
  output logic                                   saturated
);
  import pcs_pkg::*;

  localparam int IW  = DATA_WIDTH + FRAC_BITS;
  localparam int SW  = DATA_WIDTH + FRAC_BITS + 28;
  localparam int GW1 = GAIN_WIDTH + 1;
  localparam int EW  = DATA_WIDTH + 1;
  localparam int PW  = GW1 + EW;
  localparam logic signed [SW-1:0] HALF = (SW'(1) << FRAC_BITS) >> 1;

  logic signed [GW1-1:0] kp_ext, ki_ext, kd_ext;
  logic signed [GW1-1:0] kp, ki, kd;
  logic signed [EW-1:0]  err, dmeas;
  logic signed [DATA_WIDTH-1:0] prev_sel, pd_clamped;
  logic signed [PW-1:0]  kp_prod, ki_prod, kd_prod;
  logic signed [IW-1:0]  lim_lo, lim_hi, integ_base;
  logic signed [SW-1:0]  integ_sum, sum, rounded;

  always_comb begin
    kp_ext = GW1'(prop_gain);
    ki_ext = GW1'(integ_gain);
    kd_ext = GW1'(deriv_gain);
    kp = ctl.reverse ? -kp_ext : kp_ext;
    ki = ctl.reverse ? -ki_ext : ki_ext;
    kd = ctl.reverse ? -kd_ext : kd_ext;

    // bumpless transfer: first automatic tick takes measurement and drive as history
    prev_sel = ctl.was_auto ? prev_meas_q : measured;
    err   = EW'(target) - EW'(measured);
    dmeas = EW'(measured) - EW'(prev_sel);

    kp_prod = kp * err;
    ki_prod = ki * err;
    kd_prod = kd * dmeas;

    lim_lo = IW'(out_low) <<< FRAC_BITS;
    lim_hi = IW'(out_high) <<< FRAC_BITS;

    // upper limit is tested first so with crossed limits a value above out_high resolves to out_high
    if (prev_drive_q > out_high) begin
      pd_clamped = out_high;
    end else if (prev_drive_q < out_low) begin
      pd_clamped = out_low;
    end else begin
      pd_clamped = prev_drive_q;
    end
    integ_base = ctl.was_auto ? integ_q : (IW'(pd_clamped) <<< FRAC_BITS);

    integ_sum = SW'(integ_base) + SW'(ki_prod);
    if (integ_sum > SW'(lim_hi)) begin
      integ_nxt = lim_hi;
    end else if (integ_sum < SW'(lim_lo)) begin
      integ_nxt = lim_lo;
    end else begin
      integ_nxt = IW'(integ_sum);
    end

    sum     = SW'(kp_prod) + SW'(integ_nxt) - SW'(kd_prod) + HALF;
    rounded = sum >>> FRAC_BITS;

    saturated = 1'b0;
    if (!ctl.auto_en) begin
      drive = manual_drive;
    end else if (rounded > SW'(out_high)) begin
      drive     = out_high;
      saturated = 1'b1;
    end else if (rounded < SW'(out_low)) begin
      drive     = out_low;
      saturated = 1'b1;
    end else begin
      drive = DATA_WIDTH'(rounded);
    end
  end

endmodule

/* src/pid_controller_step_unit.sv */
// Fixed-point pid controller step with derivative on measurement.
// Input channel (in_valid/in_ready) carries one sample tick per item:
// measured value, setpoint, manual drive and the automatic-mode flag.
// Result channel (out_valid/out_ready) returns one item per input item:
// the drive value and a flag that the automatic drive hit a limit.
// Configuration port: cfg_wen writes cfg_wdata to register cfg_index
// (0 prop gain, 1 integ gain, 2 deriv gain, 3 out low, 4 out high,
// 5 reverse); other indexes are ignored. Write only while the unit is idle.
// An accepted item passes through the input register and then the result
// register. Throughput: one item per cycle while the receiver takes results;
// the input register feeds three gain multipliers, the integrator clamp and
// the output round-and-clamp, all settled before the result register, and the
// controller state is updated as the item enters the result register.
// A stalled receiver holds the result register, the input register then
// fills and in_ready drops; nothing is lost or repeated.
// Synchronous reset: gains 0, limits 0 and 255, direct acting, integrator,
// history and mode cleared (manual), both channels empty.
`timescale 1ns / 1ps
`include "pid_controller_step_unit_defines.svh"

module pid_controller_step_unit #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 12,
  localparam int CFG_W = (DATA_WIDTH > pcs_pkg::GAIN_WIDTH) ? DATA_WIDTH
                                                            : pcs_pkg::GAIN_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [DATA_WIDTH-1:0]       in_measured,
  input  logic signed [DATA_WIDTH-1:0]       in_target,
  input  logic signed [DATA_WIDTH-1:0]       in_manual_drive,
  input  logic                               in_auto_enable,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [DATA_WIDTH-1:0]       out_drive,
  output logic                               out_saturated,
  input  logic                               cfg_wen,
  input  logic [pcs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]                   cfg_wdata
);
  import pcs_pkg::*;

  localparam int IW = DATA_WIDTH + FRAC_BITS;

  // configuration
  logic signed [GAIN_WIDTH-1:0] prop_gain_r, integ_gain_r, deriv_gain_r;
  logic signed [DATA_WIDTH-1:0] out_low_r, out_high_r;
  logic                         reverse_r;

  // controller state
  logic signed [IW-1:0]         integ_r, integ_nxt;
  logic signed [DATA_WIDTH-1:0] prev_meas_r, prev_drive_r;
  logic                         was_auto_r;

  // input register
  logic                         s1_valid_r;
  logic signed [DATA_WIDTH-1:0] s1_meas_r, s1_target_r, s1_manual_r;
  logic                         s1_auto_r;

  // result register
  logic                         out_valid_r;
  logic signed [DATA_WIDTH-1:0] out_drive_r;
  logic                         out_sat_r;

  logic                         move;
  ctl_t                         ctl;
  logic signed [DATA_WIDTH-1:0] drive_nxt;
  logic                         sat_nxt;

  assign move     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || move;

  assign out_valid     = out_valid_r;
  assign out_drive     = out_drive_r;
  assign out_saturated = out_sat_r;

  assign ctl.auto_en  = s1_auto_r;
  assign ctl.was_auto = was_auto_r;
  assign ctl.reverse  = reverse_r;

  pcs_datapath #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .ctl          (ctl),
    .prop_gain    (prop_gain_r),
    .integ_gain   (integ_gain_r),
    .deriv_gain   (deriv_gain_r),
    .out_low      (out_low_r),
    .out_high     (out_high_r),
    .measured     (s1_meas_r),
    .target       (s1_target_r),
    .manual_drive (s1_manual_r),
    .integ_q      (integ_r),
    .prev_meas_q  (prev_meas_r),
    .prev_drive_q (prev_drive_r),
    .integ_nxt    (integ_nxt),
    .drive        (drive_nxt),
    .saturated    (sat_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= '0;
      integ_gain_r <= '0;
      deriv_gain_r <= '0;
      out_low_r    <= '0;
      out_high_r   <= DATA_WIDTH'(OUT_HIGH_RST);
      reverse_r    <= 1'b0;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_PROP_GAIN:  prop_gain_r  <= cfg_wdata[GAIN_WIDTH-1:0];
        REG_INTEG_GAIN: integ_gain_r <= cfg_wdata[GAIN_WIDTH-1:0];
        REG_DERIV_GAIN: deriv_gain_r <= cfg_wdata[GAIN_WIDTH-1:0];
        REG_OUT_LOW:    out_low_r    <= cfg_wdata[DATA_WIDTH-1:0];
        REG_OUT_HIGH:   out_high_r   <= cfg_wdata[DATA_WIDTH-1:0];
        REG_REVERSE:    reverse_r    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // state follows each item as it enters the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r      <= '0;
      prev_meas_r  <= '0;
      prev_drive_r <= '0;
      was_auto_r   <= 1'b0;
    end else if (move) begin
      prev_drive_r <= drive_nxt;
      was_auto_r   <= s1_auto_r;
      if (s1_auto_r) begin
        integ_r     <= integ_nxt;
        prev_meas_r <= s1_meas_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_meas_r   <= in_measured;
      s1_target_r <= in_target;
      s1_manual_r <= in_manual_drive;
      s1_auto_r   <= in_auto_enable;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_drive_r <= drive_nxt;
      out_sat_r   <= sat_nxt;
    end
  end

  `PCS_ASSERT_IMP(a_sat_at_limit, out_valid_r && out_sat_r, (out_drive_r == out_high_r) || (out_drive_r == out_low_r))
  `PCS_ASSERT_NXT(a_move_fills_out, move, out_valid_r)
  `PCS_ASSERT_IMP(a_stall_blocks_input, s1_valid_r && !move, !in_ready)
  `PCS_ASSERT_NXT(a_mode_tracks_item, move, was_auto_r == $past(s1_auto_r))

endmodule
